// ----- design/glyph_coverage_alpha_blend_macros.svh -----
// Assertion macros for the glyph blend RTL, included by gcab_coord.
// Depends on a clock named clock and an active-high reset named reset in scope.
`ifndef GLYPH_COVERAGE_ALPHA_BLEND_MACROS_SVH
`define GLYPH_COVERAGE_ALPHA_BLEND_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GCAB_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define GCAB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/gcab_pkg.sv -----
// Package for the glyph coverage alpha blend block: register map, config and result types,
// and the per-channel mix function. No dependencies.
`default_nettype none

package gcab_pkg;

   localparam int COORD_W       = 16;
   localparam int COLOR_W       = 24;
   localparam int CHAN_W        = 8;
   localparam int GLYPH_WIDTH_W = 9;
   localparam int REG_INDEX_W   = 3;

   typedef enum logic [REG_INDEX_W-1:0] {
      REG_BLEND_COLOR = 3'd0,
      REG_ORIGIN_X    = 3'd1,
      REG_ORIGIN_Y    = 3'd2,
      REG_GLYPH_WIDTH = 3'd3,
      REG_CLIP_LEFT   = 3'd4,
      REG_CLIP_TOP    = 3'd5,
      REG_CLIP_RIGHT  = 3'd6,
      REG_CLIP_BOTTOM = 3'd7
   } gcab_reg_type;

   typedef struct packed {
      logic [COLOR_W-1:0]       blend_color;
      logic [COORD_W-1:0]       origin_x;
      logic [COORD_W-1:0]       origin_y;
      logic [GLYPH_WIDTH_W-1:0] glyph_width;
      logic [COORD_W-1:0]       clip_left;
      logic [COORD_W-1:0]       clip_top;
      logic [COORD_W-1:0]       clip_right;
      logic [COORD_W-1:0]       clip_bottom;
   } gcab_cfg_type;

   typedef struct packed {
      logic                 write_enable;
      logic [COLOR_W-1:0]   blended_pixel;
      logic [COORD_W-1:0]   pixel_y;
      logic [COORD_W-1:0]   pixel_x;
   } gcab_result_type;

   // (fg*a + bg*(255-a)) / 255, truncated. The sum stays below 65536, where
   // (s + (s >> 8) + 1) >> 8 equals s / 255 exactly.
   function automatic logic [CHAN_W-1:0] mix_channel(
      input logic [CHAN_W-1:0] fg,
      input logic [CHAN_W-1:0] bg,
      input logic [CHAN_W-1:0] a
   );
      logic [CHAN_W-1:0]   inv_a;
      logic [2*CHAN_W-1:0] sum;
      logic [2*CHAN_W:0]   t;
      inv_a = ~a;
      sum = (2*CHAN_W)'(fg) * (2*CHAN_W)'(a) + (2*CHAN_W)'(bg) * (2*CHAN_W)'(inv_a);
      t   = (2*CHAN_W+1)'(sum) + (2*CHAN_W+1)'(sum[2*CHAN_W-1:CHAN_W]) + (2*CHAN_W+1)'(1);
      return t[2*CHAN_W-1:CHAN_W];
   endfunction

endpackage

`default_nettype wire

// ----- design/glyph_coverage_alpha_blend.sv -----
// Glyph coverage alpha blend, top level.
// Request channel (req_*): one glyph coverage byte per request in raster order, with the
// background RGB888 pixel at that spot; req_tlast marks the last byte of the glyph.
// Response channel (rsp_*): one result per request, carrying the destination x and y,
// the blended pixel (background unchanged when nothing is written) and, on rsp_tuser,
// the write enable (coverage nonzero and point inside the half-open clip rectangle).
// Config channel (csr_*): one register write per handshake, always ready; write only
// while no request is in flight.
// Throughput: one request per cycle while rsp_tready is high. A request passes through
// the input register, then the blend/clip logic into the response register, which drives
// the response. The column/row counters advance on each accepted request.
// Stall: when rsp_tready is low the response register holds; the input register keeps
// taking a request while it is empty, then req_tready drops until the response drains.
// Reset: synchronous, active high; clears both valid flags, the counters and the config
// registers (glyph_width resets to 1, all others to 0).
// Depends on gcab_pkg, gcab_csr, gcab_coord and gcab_blend.
`default_nettype none

module glyph_coverage_alpha_blend
   import gcab_pkg::*;
#(
   parameter int MAX_GLYPH_SIDE = 256
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // config write channel
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [REG_INDEX_W-1:0] csr_index,
   input  wire logic [COLOR_W-1:0]     csr_wdata,
   // request channel
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [31:0]            req_tdata,   // coverage[7:0], background[31:8]
   input  wire logic                   req_tlast,   // glyph_end
   // response channel
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [55:0]                 rsp_tdata,   // pixel_x[15:0], pixel_y[31:16],
                                                    // blended_pixel[55:32]
   output logic                        rsp_tuser    // write_enable
);

   localparam int CW = $clog2(MAX_GLYPH_SIDE);

   gcab_cfg_type    cfg;
   gcab_result_type result;

   logic               req_accept;
   logic               s1_advance;
   logic               rsp_free;

   // Input register stage: request payload plus the counter snapshot for it.
   logic               s1_valid_ff, s1_valid_in;
   logic [CHAN_W-1:0]  s1_cov_ff;
   logic [COLOR_W-1:0] s1_bg_ff;
   logic [CW-1:0]      s1_col_ff;
   logic [CW-1:0]      s1_row_ff;
   logic [CW-1:0]      col_count;
   logic [CW-1:0]      row_count;

   // Response register stage.
   logic               rsp_valid_ff, rsp_valid_in;
   gcab_result_type    rsp_data_ff;

   assign csr_ready = 1'b1;

   gcab_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   // Advance the response register when it is empty or being taken.
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign s1_advance = s1_valid_ff && rsp_free;
   assign req_tready = !s1_valid_ff || rsp_free;
   assign req_accept = req_tvalid && req_tready;

   gcab_coord #(
      .MAX_GLYPH_SIDE (MAX_GLYPH_SIDE)
   ) u_coord (
      .clock       (clock),
      .reset       (reset),
      .advance     (req_accept),
      .last        (req_tlast),
      .glyph_width (cfg.glyph_width),
      .col_count   (col_count),
      .row_count   (row_count)
   );

   gcab_blend #(
      .CNT_W (CW)
   ) u_blend (
      .cfg        (cfg),
      .coverage   (s1_cov_ff),
      .background (s1_bg_ff),
      .col_count  (s1_col_ff),
      .row_count  (s1_row_ff),
      .result     (result)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: load on a handshake, otherwise hold.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_cov_ff <= req_tdata[7:0];
         s1_bg_ff  <= req_tdata[31:8];
         s1_col_ff <= col_count;
         s1_row_ff <= row_count;
      end
      if (s1_advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_data_ff.blended_pixel, rsp_data_ff.pixel_y, rsp_data_ff.pixel_x};
   assign rsp_tuser  = rsp_data_ff.write_enable;

endmodule

`default_nettype wire

// ----- design/gcab_csr.sv -----
// Configuration register file for the glyph blend block.
// Depends on gcab_pkg for the register map and config struct.
`default_nettype none

module gcab_csr
   import gcab_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   wr_en,
   input  wire logic [REG_INDEX_W-1:0] wr_index,
   input  wire logic [COLOR_W-1:0]     wr_data,
   output gcab_cfg_type                cfg
);

   // Everything clears except the glyph width, which comes up as one column.
   localparam gcab_cfg_type CFG_RESET = '{glyph_width: GLYPH_WIDTH_W'(1), default: '0};

   gcab_cfg_type cfg_ff;
   gcab_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (gcab_reg_type'(wr_index))
            REG_BLEND_COLOR: cfg_in.blend_color = wr_data;
            REG_ORIGIN_X:    cfg_in.origin_x    = wr_data[COORD_W-1:0];
            REG_ORIGIN_Y:    cfg_in.origin_y    = wr_data[COORD_W-1:0];
            REG_GLYPH_WIDTH: cfg_in.glyph_width = wr_data[GLYPH_WIDTH_W-1:0];
            REG_CLIP_LEFT:   cfg_in.clip_left   = wr_data[COORD_W-1:0];
            REG_CLIP_TOP:    cfg_in.clip_top    = wr_data[COORD_W-1:0];
            REG_CLIP_RIGHT:  cfg_in.clip_right  = wr_data[COORD_W-1:0];
            REG_CLIP_BOTTOM: cfg_in.clip_bottom = wr_data[COORD_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- design/gcab_coord.sv -----
// Column and row counters that walk the glyph bitmap in raster order.
// Depends on gcab_pkg for the glyph width field size and the assertion macros header.
`default_nettype none

module gcab_coord
   import gcab_pkg::*;
#(
   parameter int MAX_GLYPH_SIDE = 256
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              advance,
   input  wire logic                              last,
   input  wire logic [GLYPH_WIDTH_W-1:0]          glyph_width,
   output logic [$clog2(MAX_GLYPH_SIDE)-1:0]      col_count,
   output logic [$clog2(MAX_GLYPH_SIDE)-1:0]      row_count
);

`include "glyph_coverage_alpha_blend_macros.svh"

   localparam int CW = $clog2(MAX_GLYPH_SIDE);
   localparam int WW = (CW + 1 > GLYPH_WIDTH_W) ? CW + 1 : GLYPH_WIDTH_W;
   localparam logic [WW-1:0] MAX_W   = WW'(MAX_GLYPH_SIDE);
   localparam logic [CW-1:0] ROW_MAX = CW'(MAX_GLYPH_SIDE - 1);

   logic [CW-1:0] col_ff, col_in;
   logic [CW-1:0] row_ff, row_in;
   logic [WW-1:0] width_raw;
   logic [WW-1:0] width_eff;
   logic [WW-1:0] col_next;
   logic          col_wrap;

   // Zero acts as one column; oversize clamps to the largest glyph side.
   always_comb begin
      width_raw = WW'(glyph_width);
      if (width_raw == '0) begin
         width_eff = WW'(1);
      end else if (width_raw > MAX_W) begin
         width_eff = MAX_W;
      end else begin
         width_eff = width_raw;
      end
   end

   assign col_next = WW'(col_ff) + WW'(1);
   assign col_wrap = (col_next >= width_eff);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (advance) begin
         if (last) begin
            col_in = '0;
            row_in = '0;
         end else if (col_wrap) begin
            col_in = '0;
            if (row_ff < ROW_MAX) begin
               row_in = row_ff + CW'(1);
            end
         end else begin
            col_in = col_next[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign col_count = col_ff;
   assign row_count = row_ff;

   `GCAB_ASSERT_NEXT(a_glyph_end_clears, advance && last, (col_ff == '0) && (row_ff == '0), "counters not cleared after glyph end")
   `GCAB_ASSERT_NEXT(a_hold_when_idle, !advance, $stable(col_ff) && $stable(row_ff), "counters moved without a request")
   `GCAB_ASSERT_NEXT(a_column_step, advance && !last && !col_wrap, (col_ff != '0) && $stable(row_ff), "column step lost or row moved mid-row")

endmodule

`default_nettype wire

// ----- design/gcab_blend.sv -----
// Per-pixel datapath: destination coordinate, clip test and RGB888 channel mix.
// Depends on gcab_pkg for the config and result structs and mix_channel.
`default_nettype none

module gcab_blend
   import gcab_pkg::*;
#(
   parameter int CNT_W = 8
) (
   input  gcab_cfg_type              cfg,
   input  wire logic [CHAN_W-1:0]    coverage,
   input  wire logic [COLOR_W-1:0]   background,
   input  wire logic [CNT_W-1:0]     col_count,
   input  wire logic [CNT_W-1:0]     row_count,
   output gcab_result_type           result
);

   logic [COORD_W-1:0] x;
   logic [COORD_W-1:0] y;
   logic               in_clip;
   logic               we;
   logic [COLOR_W-1:0] mixed;

   // Coordinates wrap at the coordinate width.
   assign x = cfg.origin_x + COORD_W'(col_count);
   assign y = cfg.origin_y + COORD_W'(row_count);

   assign in_clip = ($signed(x) >= $signed(cfg.clip_left))  &&
                    ($signed(x) <  $signed(cfg.clip_right)) &&
                    ($signed(y) >= $signed(cfg.clip_top))   &&
                    ($signed(y) <  $signed(cfg.clip_bottom));
   assign we = (coverage != '0) && in_clip;

   assign mixed = {mix_channel(cfg.blend_color[23:16], background[23:16], coverage),
                   mix_channel(cfg.blend_color[15:8],  background[15:8],  coverage),
                   mix_channel(cfg.blend_color[7:0],   background[7:0],   coverage)};

   always_comb begin
      result.pixel_x       = x;
      result.pixel_y       = y;
      result.write_enable  = we;
      result.blended_pixel = we ? mixed : background;
   end

endmodule

`default_nettype wire
